>>> design/bva_pkg.sv
// Package for the butterfly vector apply block: data widths, fixed-point
// constants, the derived internal widths and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package bva_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;

	// Full product, difference/sum of two products, rounded part, sum of two parts
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int ACC_W  = PROD_W + 1;
	localparam int RND_W  = ACC_W - FRAC_BITS;
	localparam int SUM_W  = RND_W + 1;

	// Request codes
	localparam logic REQ_FORWARD   = 1'b0;
	localparam logic REQ_TRANSPOSE = 1'b1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic signed [RND_W-1:0]      rnd_t;
	typedef logic signed [SUM_W-1:0]      sum_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam acc_t  RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

	// Clamp a wide signed value to the data range
	function automatic data_t sat_data(input sum_t v);
		logic all_one;
		logic all_zero;
		all_one  = &v[SUM_W-1:DATA_WIDTH-1];
		all_zero = ~|v[SUM_W-1:DATA_WIDTH-1];
		if (all_one || all_zero)
			return v[DATA_WIDTH-1:0];
		else
			return v[SUM_W-1] ? DATA_MIN : DATA_MAX;
	endfunction

endpackage

>>> design/butterfly_vector_apply.sv
// Top level of the butterfly vector apply block: one complex butterfly per word.
// Depends on bva_pkg for widths, constants and saturation.
`timescale 1ns / 1ps

// Complex butterfly on one top/bottom element pair of a depth-one random
// butterfly transform, signed Q3.12 (bva_pkg::DATA_WIDTH / FRAC_BITS).
// A word is taken on every rising edge where start is high; busy is always low,
// so a new word may follow in every cycle. Each word gives exactly one result
// word, marked by done for one cycle, after it passes in turn through the
// input register, then the pre-add and the eight 16x16 multipliers into the
// product register, then rounding, combining and saturation into the output
// register. The receiver cannot stall; it must take each result word while
// done is high. Forward requests weight each element and then sum/difference;
// transpose requests sum/difference (saturated) and then weight. A missing
// bottom element counts as zero and clears bot_written; a lone vector in
// transpose mode passes the top element through unchanged.
module butterfly_vector_apply (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  logic                req_type,
	input  logic                has_bottom,
	input  logic                lone_vector,
	input  bva_pkg::data_t      u_top_re,
	input  bva_pkg::data_t      u_top_im,
	input  bva_pkg::data_t      u_bot_re,
	input  bva_pkg::data_t      u_bot_im,
	input  bva_pkg::data_t      b_top_re,
	input  bva_pkg::data_t      b_top_im,
	input  bva_pkg::data_t      b_bot_re,
	input  bva_pkg::data_t      b_bot_im,
	output bva_pkg::data_t      out_top_re,
	output bva_pkg::data_t      out_top_im,
	output bva_pkg::data_t      out_bot_re,
	output bva_pkg::data_t      out_bot_im,
	output logic                bot_written
);

	// ---------------------------------------------------------------
	// Stage 1: input register. Drop the bottom element when it does
	// not exist so every later stage sees a plain zero.
	// ---------------------------------------------------------------
	logic           vld_s1;
	logic           trn_s1;
	logic           bot_s1;
	logic           lone_s1;
	bva_pkg::data_t utr_s1, uti_s1, ubr_s1, ubi_s1;
	bva_pkg::data_t btr_s1, bti_s1, bbr_s1, bbi_s1;

	logic in_bot;
	assign in_bot = has_bottom & ~lone_vector;

	// The datapath never stalls
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			trn_s1  <= req_type;
			bot_s1  <= in_bot;
			lone_s1 <= lone_vector;
			utr_s1  <= u_top_re;
			uti_s1  <= u_top_im;
			ubr_s1  <= u_bot_re;
			ubi_s1  <= u_bot_im;
			btr_s1  <= b_top_re;
			bti_s1  <= b_top_im;
			bbr_s1  <= in_bot ? b_bot_re : '0;
			bbi_s1  <= in_bot ? b_bot_im : '0;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 logic: transpose pre-add with saturation, operand
	// select, then the two complex multiplies (eight real products).
	// ---------------------------------------------------------------
	bva_pkg::data_t sr, si, dr, di;
	bva_pkg::data_t opt_re, opt_im, opb_re, opb_im;
	bva_pkg::prod_t p_trr, p_tii, p_tri, p_tir;
	bva_pkg::prod_t p_brr, p_bii, p_bri, p_bir;

	always_comb begin
		sr = bva_pkg::sat_data(bva_pkg::SUM_W'(btr_s1) + bva_pkg::SUM_W'(bbr_s1));
		si = bva_pkg::sat_data(bva_pkg::SUM_W'(bti_s1) + bva_pkg::SUM_W'(bbi_s1));
		dr = bva_pkg::sat_data(bva_pkg::SUM_W'(btr_s1) - bva_pkg::SUM_W'(bbr_s1));
		di = bva_pkg::sat_data(bva_pkg::SUM_W'(bti_s1) - bva_pkg::SUM_W'(bbi_s1));

		if (trn_s1 == bva_pkg::REQ_TRANSPOSE) begin
			opt_re = sr;
			opt_im = si;
			opb_re = dr;
			opb_im = di;
		end else begin
			opt_re = btr_s1;
			opt_im = bti_s1;
			opb_re = bbr_s1;
			opb_im = bbi_s1;
		end

		p_trr = bva_pkg::PROD_W'(utr_s1) * bva_pkg::PROD_W'(opt_re);
		p_tii = bva_pkg::PROD_W'(uti_s1) * bva_pkg::PROD_W'(opt_im);
		p_tri = bva_pkg::PROD_W'(utr_s1) * bva_pkg::PROD_W'(opt_im);
		p_tir = bva_pkg::PROD_W'(uti_s1) * bva_pkg::PROD_W'(opt_re);
		p_brr = bva_pkg::PROD_W'(ubr_s1) * bva_pkg::PROD_W'(opb_re);
		p_bii = bva_pkg::PROD_W'(ubi_s1) * bva_pkg::PROD_W'(opb_im);
		p_bri = bva_pkg::PROD_W'(ubr_s1) * bva_pkg::PROD_W'(opb_im);
		p_bir = bva_pkg::PROD_W'(ubi_s1) * bva_pkg::PROD_W'(opb_re);
	end

	// ---------------------------------------------------------------
	// Stage 2: product register. Carry the top element along for the
	// lone-vector pass-through.
	// ---------------------------------------------------------------
	logic           vld_s2;
	logic           trn_s2;
	logic           bot_s2;
	logic           pass_s2;
	bva_pkg::data_t btr_s2, bti_s2;
	bva_pkg::prod_t trr_s2, tii_s2, tri_s2, tir_s2;
	bva_pkg::prod_t brr_s2, bii_s2, bri_s2, bir_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			trn_s2  <= trn_s1;
			bot_s2  <= bot_s1;
			pass_s2 <= lone_s1 & (trn_s1 == bva_pkg::REQ_TRANSPOSE);
			btr_s2  <= btr_s1;
			bti_s2  <= bti_s1;
			trr_s2  <= p_trr;
			tii_s2  <= p_tii;
			tri_s2  <= p_tri;
			tir_s2  <= p_tir;
			brr_s2  <= p_brr;
			bii_s2  <= p_bii;
			bri_s2  <= p_bri;
			bir_s2  <= p_bir;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2 logic: combine products, round half up by adding one
	// half and dropping the fraction, then sum/difference (forward only) and clamp.
	// ---------------------------------------------------------------
	bva_pkg::acc_t  at_re, at_im, ab_re, ab_im;
	bva_pkg::rnd_t  rt_re, rt_im, rb_re, rb_im;
	bva_pkg::data_t nt_re, nt_im, nb_re, nb_im;

	always_comb begin
		at_re = bva_pkg::ACC_W'(trr_s2) - bva_pkg::ACC_W'(tii_s2) + bva_pkg::RND_HALF;
		at_im = bva_pkg::ACC_W'(tri_s2) + bva_pkg::ACC_W'(tir_s2) + bva_pkg::RND_HALF;
		ab_re = bva_pkg::ACC_W'(brr_s2) - bva_pkg::ACC_W'(bii_s2) + bva_pkg::RND_HALF;
		ab_im = bva_pkg::ACC_W'(bri_s2) + bva_pkg::ACC_W'(bir_s2) + bva_pkg::RND_HALF;

		rt_re = at_re[bva_pkg::ACC_W-1:bva_pkg::FRAC_BITS];
		rt_im = at_im[bva_pkg::ACC_W-1:bva_pkg::FRAC_BITS];
		rb_re = ab_re[bva_pkg::ACC_W-1:bva_pkg::FRAC_BITS];
		rb_im = ab_im[bva_pkg::ACC_W-1:bva_pkg::FRAC_BITS];

		if (pass_s2) begin
			nt_re = btr_s2;
			nt_im = bti_s2;
		end else if (trn_s2 == bva_pkg::REQ_TRANSPOSE) begin
			nt_re = bva_pkg::sat_data(bva_pkg::SUM_W'(rt_re));
			nt_im = bva_pkg::sat_data(bva_pkg::SUM_W'(rt_im));
		end else begin
			// a missing bottom already gave zero bottom products here
			nt_re = bva_pkg::sat_data(bva_pkg::SUM_W'(rt_re) + bva_pkg::SUM_W'(rb_re));
			nt_im = bva_pkg::sat_data(bva_pkg::SUM_W'(rt_im) + bva_pkg::SUM_W'(rb_im));
		end

		if (!bot_s2) begin
			nb_re = '0;
			nb_im = '0;
		end else if (trn_s2 == bva_pkg::REQ_TRANSPOSE) begin
			nb_re = bva_pkg::sat_data(bva_pkg::SUM_W'(rb_re));
			nb_im = bva_pkg::sat_data(bva_pkg::SUM_W'(rb_im));
		end else begin
			nb_re = bva_pkg::sat_data(bva_pkg::SUM_W'(rt_re) - bva_pkg::SUM_W'(rb_re));
			nb_im = bva_pkg::sat_data(bva_pkg::SUM_W'(rt_im) - bva_pkg::SUM_W'(rb_im));
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: output register; done marks each result word.
	// ---------------------------------------------------------------
	logic done_q;
	logic botw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			botw_q <= 1'b0;
		end else begin
			done_q <= vld_s2;
			botw_q <= vld_s2 & bot_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			out_top_re <= nt_re;
			out_top_im <= nt_im;
			out_bot_re <= nb_re;
			out_bot_im <= nb_im;
		end
	end

	assign done        = done_q;
	assign bot_written = botw_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("accepted word gave no result three cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result word without an accepted word");

	a_botw_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		bot_written |-> done)
		else $error("bot_written outside a result word");

	a_botw_source: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bot_written) |-> ($past(has_bottom, 3) && !$past(lone_vector, 3)))
		else $error("bot_written without a bottom element");

	a_bot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !bot_written) |-> (out_bot_re == '0 && out_bot_im == '0))
		else $error("bottom result not cleared for a missing bottom");

endmodule

>>> bench/butterfly_vector_apply_tb.sv
// Self-checking bench for butterfly_vector_apply: directed and random butterfly words,
// each result word checked against a predictor kept in this file.
// Depends on bva_pkg and the butterfly_vector_apply RTL.
`timescale 1ns / 1ps

module butterfly_vector_apply_tb;

	localparam int CLK_PERIOD  = 20;
	localparam int PIPE_DEPTH  = 3;     // depth of the result pipeline, used in the drain wait
	localparam int IDLE_PCT    = 34;
	localparam int RANDOM_WORDS = 1450;

	// Short local names for the request codes and rails
	localparam logic           FWD  = bva_pkg::REQ_FORWARD;
	localparam logic           TRN  = bva_pkg::REQ_TRANSPOSE;
	localparam bva_pkg::data_t VMAX = bva_pkg::DATA_MAX;
	localparam bva_pkg::data_t VMIN = bva_pkg::DATA_MIN;

	// One input word as it goes onto the ports
	typedef struct {
		logic           req_type;
		logic           has_bottom;
		logic           lone_vector;
		bva_pkg::data_t u_top_re;
		bva_pkg::data_t u_top_im;
		bva_pkg::data_t u_bot_re;
		bva_pkg::data_t u_bot_im;
		bva_pkg::data_t b_top_re;
		bva_pkg::data_t b_top_im;
		bva_pkg::data_t b_bot_re;
		bva_pkg::data_t b_bot_im;
	} bfly_word_t;

	// One result word
	typedef struct {
		bva_pkg::data_t top_re;
		bva_pkg::data_t top_im;
		bva_pkg::data_t bot_re;
		bva_pkg::data_t bot_im;
		logic           bot_written;
	} bfly_result_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic           done;
	logic           req_type;
	logic           has_bottom;
	logic           lone_vector;
	bva_pkg::data_t u_top_re;
	bva_pkg::data_t u_top_im;
	bva_pkg::data_t u_bot_re;
	bva_pkg::data_t u_bot_im;
	bva_pkg::data_t b_top_re;
	bva_pkg::data_t b_top_im;
	bva_pkg::data_t b_bot_re;
	bva_pkg::data_t b_bot_im;
	bva_pkg::data_t out_top_re;
	bva_pkg::data_t out_top_im;
	bva_pkg::data_t out_bot_re;
	bva_pkg::data_t out_bot_im;
	logic           bot_written;

	bfly_result_t expected_words[$];
	int           mismatch_count;
	bit           steady_sender;   // when set, the sender never idles

	butterfly_vector_apply uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.req_type    (req_type),
		.has_bottom  (has_bottom),
		.lone_vector (lone_vector),
		.u_top_re    (u_top_re),
		.u_top_im    (u_top_im),
		.u_bot_re    (u_bot_re),
		.u_bot_im    (u_bot_im),
		.b_top_re    (b_top_re),
		.b_top_im    (b_top_im),
		.b_bot_re    (b_bot_re),
		.b_bot_im    (b_bot_im),
		.out_top_re  (out_top_re),
		.out_top_im  (out_top_im),
		.out_bot_re  (out_bot_re),
		.out_bot_im  (out_bot_im),
		.bot_written (bot_written)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: 64-bit signed arithmetic is wide enough for every
	// product and sum here, so round and clamp directly.
	// ------------------------------------------------------------------

	// Clamp to the signed data range
	function automatic longint clamp_data(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bva_pkg::DATA_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Divide by 2^FRAC_BITS, half rounds toward plus infinity
	function automatic longint round_frac(input longint v);
		return (v + (longint'(1) <<< (bva_pkg::FRAC_BITS - 1))) >>> bva_pkg::FRAC_BITS;
	endfunction

	// Rounded complex product; parts are not yet clamped
	function automatic void complex_mul(input longint ar, input longint ai,
			input longint br, input longint bi, output longint re, output longint im);
		re = round_frac(ar * br - ai * bi);
		im = round_frac(ar * bi + ai * br);
	endfunction

	function automatic bfly_result_t predict_butterfly(input bfly_word_t w);
		bfly_result_t r;
		bit     transpose;
		bit     bottom;
		longint utr, uti, ubr, ubi, btr, bti, bbr, bbi;
		longint tr, ti, xr, xi;
		longint sr, si, dr, di;
		longint ar, ai, cr, ci;
		transpose = (w.req_type == bva_pkg::REQ_TRANSPOSE);
		bottom    = w.has_bottom && !w.lone_vector;
		utr = longint'(w.u_top_re);
		uti = longint'(w.u_top_im);
		ubr = longint'(w.u_bot_re);
		ubi = longint'(w.u_bot_im);
		btr = longint'(w.b_top_re);
		bti = longint'(w.b_top_im);
		// a missing bottom element counts as zero
		bbr = bottom ? longint'(w.b_bot_re) : 0;
		bbi = bottom ? longint'(w.b_bot_im) : 0;
		xr = 0;
		xi = 0;
		cr = 0;
		ci = 0;
		if (transpose && w.lone_vector) begin
			// lone vector in transpose: top passes through untouched
			tr = btr;
			ti = bti;
		end else if (transpose) begin
			sr = clamp_data(btr + bbr);
			si = clamp_data(bti + bbi);
			dr = clamp_data(btr - bbr);
			di = clamp_data(bti - bbi);
			complex_mul(utr, uti, sr, si, tr, ti);
			tr = clamp_data(tr);
			ti = clamp_data(ti);
			if (bottom) begin
				complex_mul(ubr, ubi, dr, di, xr, xi);
				xr = clamp_data(xr);
				xi = clamp_data(xi);
			end
		end else begin
			complex_mul(utr, uti, btr, bti, ar, ai);
			if (bottom)
				complex_mul(ubr, ubi, bbr, bbi, cr, ci);
			tr = clamp_data(ar + cr);
			ti = clamp_data(ai + ci);
			if (bottom) begin
				xr = clamp_data(ar - cr);
				xi = clamp_data(ai - ci);
			end
		end
		r.top_re      = bva_pkg::data_t'(tr);
		r.top_im      = bva_pkg::data_t'(ti);
		r.bot_re      = bva_pkg::data_t'(xr);
		r.bot_im      = bva_pkg::data_t'(xi);
		r.bot_written = bottom && !(transpose && w.lone_vector);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Word construction
	// ------------------------------------------------------------------

	function automatic bfly_word_t make_word(input logic req, input logic hb,
			input logic lone,
			input bva_pkg::data_t utr, input bva_pkg::data_t uti,
			input bva_pkg::data_t ubr, input bva_pkg::data_t ubi,
			input bva_pkg::data_t btr, input bva_pkg::data_t bti,
			input bva_pkg::data_t bbr, input bva_pkg::data_t bbi);
		bfly_word_t w;
		w.req_type    = req;
		w.has_bottom  = hb;
		w.lone_vector = lone;
		w.u_top_re    = utr;
		w.u_top_im    = uti;
		w.u_bot_re    = ubr;
		w.u_bot_im    = ubi;
		w.b_top_re    = btr;
		w.b_top_im    = bti;
		w.b_bot_re    = bbr;
		w.b_bot_im    = bbi;
		return w;
	endfunction

	// Mix of rails, values near one, and full-range noise
	function automatic bva_pkg::data_t random_value();
		int v;
		case ($urandom_range(7))
			0: return VMAX;
			1: return VMIN;
			2: begin
				v = int'($urandom_range(2)) - 1;
				return bva_pkg::data_t'(v);
			end
			3, 4: begin
				v = int'($urandom_range(16384)) - 8192;
				return bva_pkg::data_t'(v);
			end
			default: return bva_pkg::data_t'($urandom_range(16'hffff, 0));
		endcase
	endfunction

	function automatic bfly_word_t random_word();
		bfly_word_t w;
		w.req_type    = $urandom_range(1) ? TRN : FWD;
		w.has_bottom  = ($urandom_range(99) < 80);
		w.lone_vector = ($urandom_range(99) < 12);
		w.u_top_re    = random_value();
		w.u_top_im    = random_value();
		w.u_bot_re    = random_value();
		w.u_bot_im    = random_value();
		w.b_top_re    = random_value();
		w.b_top_im    = random_value();
		w.b_bot_re    = random_value();
		w.b_bot_im    = random_value();
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Sender and checker
	// ------------------------------------------------------------------

	// Send one word: idle a random while, then hold start until taken.
	// start stays high on return so back-to-back words need no toggle.
	task automatic drive_word(input bfly_word_t w);
		@(negedge clk);
		while (!steady_sender && $urandom_range(99) < IDLE_PCT) begin
			start = 1'b0;
			@(negedge clk);
		end
		start       = 1'b1;
		req_type    = w.req_type;
		has_bottom  = w.has_bottom;
		lone_vector = w.lone_vector;
		u_top_re    = w.u_top_re;
		u_top_im    = w.u_top_im;
		u_bot_re    = w.u_bot_re;
		u_bot_im    = w.u_bot_im;
		b_top_re    = w.b_top_re;
		b_top_im    = w.b_top_im;
		b_bot_re    = w.b_bot_re;
		b_bot_im    = w.b_bot_im;
		// hold the word until an edge sees busy low
		do
			@(posedge clk);
		while (busy);
		expected_words.push_back(predict_butterfly(w));
	endtask

	// Drop start and wait for every outstanding result word
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Compare each result word, field by field, with the oldest prediction
	always @(posedge clk) begin
		bfly_result_t exp_r;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				exp_r = expected_words.pop_front();
				if (out_top_re !== exp_r.top_re)
					report_mismatch($sformatf("out_top_re %0d, want %0d",
						out_top_re, exp_r.top_re));
				if (out_top_im !== exp_r.top_im)
					report_mismatch($sformatf("out_top_im %0d, want %0d",
						out_top_im, exp_r.top_im));
				if (out_bot_re !== exp_r.bot_re)
					report_mismatch($sformatf("out_bot_re %0d, want %0d",
						out_bot_re, exp_r.bot_re));
				if (out_bot_im !== exp_r.bot_im)
					report_mismatch($sformatf("out_bot_im %0d, want %0d",
						out_bot_im, exp_r.bot_im));
				if (bot_written !== exp_r.bot_written)
					report_mismatch($sformatf("bot_written %b, want %b",
						bot_written, exp_r.bot_written));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Rails in both modes: full-scale products, sum and difference overflow
	task automatic test_extremes();
		drive_word(make_word(FWD, 1'b1, 1'b0, VMAX, VMAX, VMAX, VMAX,
			VMAX, VMAX, VMAX, VMAX));
		drive_word(make_word(FWD, 1'b1, 1'b0, VMIN, VMIN, VMIN, VMIN,
			VMIN, VMIN, VMIN, VMIN));
		drive_word(make_word(FWD, 1'b1, 1'b0, VMIN, VMAX, VMAX, VMIN,
			VMAX, VMIN, VMIN, VMAX));
		drive_word(make_word(TRN, 1'b1, 1'b0, VMAX, VMAX, VMAX, VMAX,
			VMAX, VMAX, VMAX, VMAX));
		drive_word(make_word(TRN, 1'b1, 1'b0, VMIN, VMIN, VMIN, VMIN,
			VMIN, VMIN, VMIN, VMIN));
		drive_word(make_word(TRN, 1'b1, 1'b0, VMAX, VMIN, VMIN, VMAX,
			VMAX, VMIN, VMIN, VMAX));
		drive_word(make_word(FWD, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
		drive_word(make_word(TRN, 1'b1, 1'b0, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
			-16'sd1, -16'sd1, -16'sd1, -16'sd1));
	endtask

	// Exact halves: +half rounds up, -half rounds to zero
	task automatic test_rounding();
		drive_word(make_word(FWD, 1'b1, 1'b0, 16'sd1, 16'sd0, 16'sd1, 16'sd0,
			16'sh0800, 16'sh0800, -16'sh0800, 16'sh0800));
		drive_word(make_word(FWD, 1'b1, 1'b0, -16'sd1, 16'sd1, 16'sd1, -16'sd1,
			16'sh0800, -16'sh0800, 16'sh0800, 16'sh0800));
		drive_word(make_word(TRN, 1'b1, 1'b0, 16'sd1, -16'sd1, -16'sd1, 16'sd1,
			16'sh0400, 16'sh0400, 16'sh0400, -16'sh0400));
		drive_word(make_word(FWD, 1'b1, 1'b0, 16'sh1000, 16'sd0, 16'sh1000, 16'sd0,
			16'sh1234, -16'sh0567, 16'sh0321, 16'sh7fff));
	endtask

	// Missing bottom: partner data must be ignored in both modes
	task automatic test_missing_bottom();
		drive_word(make_word(FWD, 1'b0, 1'b0, 16'sh1800, -16'sh0900, VMAX, VMIN,
			16'sh2000, 16'sh0700, VMAX, VMIN));
		drive_word(make_word(TRN, 1'b0, 1'b0, 16'sh1800, -16'sh0900, VMIN, VMAX,
			16'sh2000, 16'sh0700, VMIN, VMAX));
		drive_word(make_word(TRN, 1'b0, 1'b0, VMIN, VMIN, VMAX, VMAX,
			VMIN, VMIN, VMAX, VMAX));
		drive_word(make_word(FWD, 1'b0, 1'b0, VMIN, VMIN, VMAX, VMAX,
			VMIN, VMAX, VMAX, VMAX));
	endtask

	// Lone vector: pass-through in transpose, missing bottom in forward
	task automatic test_lone_vector();
		drive_word(make_word(TRN, 1'b1, 1'b1, VMAX, VMIN, VMAX, VMIN,
			16'sh5a5a, -16'sh2345, VMAX, VMIN));
		drive_word(make_word(TRN, 1'b0, 1'b1, 16'sh1000, 16'sh1000, 16'sd0, 16'sd0,
			VMIN, VMAX, 16'sh1111, 16'sh2222));
		drive_word(make_word(FWD, 1'b1, 1'b1, 16'sh0c00, -16'sh0400, VMAX, VMAX,
			16'sh3000, 16'sh1000, VMAX, VMAX));
		drive_word(make_word(FWD, 1'b0, 1'b1, VMIN, VMIN, 16'sd5, 16'sd7,
			VMIN, VMIN, 16'sd9, 16'sd3));
	endtask

	// Random words, with one long stretch where the sender never idles
	task automatic test_random_words();
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady_sender = (n >= 500 && n < 800);
			drive_word(random_word());
		end
		steady_sender = 1'b0;
	endtask

	// Pause the sender until the pipe is empty, then burst back in
	task automatic test_drain_and_resume();
		repeat (5) drive_word(random_word());
		drain_results();
		steady_sender = 1'b1;
		repeat (8) drive_word(random_word());
		steady_sender = 1'b0;
	endtask

	// Run limit: far above the slowest correct run
	initial begin
		#(CLK_PERIOD * 200000);
		$display("FAIL");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		steady_sender  = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = FWD;
		has_bottom  = 1'b0;
		lone_vector = 1'b0;
		u_top_re    = '0;
		u_top_im    = '0;
		u_bot_re    = '0;
		u_bot_im    = '0;
		b_top_re    = '0;
		b_top_im    = '0;
		b_bot_re    = '0;
		b_bot_im    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_rounding();
		test_missing_bottom();
		test_lone_vector();
		test_drain_and_resume();
		test_random_words();

		drain_results();
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
design/bva_pkg.sv
design/butterfly_vector_apply.sv
bench/butterfly_vector_apply_tb.sv
